>>> rtl/core/ffha_pkg.sv
// Package for the first-fit heap allocator.
// Sizes, header format, status and function codes and small helpers.
// No dependencies.
`default_nettype none
package ffha_pkg;

  localparam int HEAP_GRANULES = 4096;
  localparam int GRANULE_BYTES = 8;
  localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);

  localparam int ADDR_W  = 32;
  localparam int REQ_W   = 16;
  localparam int LIMIT_W = 13;
  localparam int IDX_W   = $clog2(HEAP_GRANULES);
  localparam int GRAN_W  = $clog2(HEAP_GRANULES + 1);
  localparam int WALK_W  = GRAN_W + 1;
  localparam int NEED_W  = REQ_W + 1 - GRAN_SHIFT;
  localparam int SUM_W   = ((NEED_W > WALK_W) ? NEED_W : WALK_W) + 2;
  localparam int OFF_W   = ADDR_W - GRAN_SHIFT;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'd1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(HEAP_GRANULES);

  typedef struct packed {
    logic              used;
    logic [GRAN_W-1:0] size;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef struct packed {
    logic [ADDR_W-1:0]  heap_base;
    logic [LIMIT_W-1:0] heap_limit;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
  } res_t;

  function automatic logic [GRAN_W-1:0] size_clamp(input logic [GRAN_W-1:0] s);
    return (s > GRAN_W'(HEAP_GRANULES)) ? GRAN_W'(HEAP_GRANULES) : s;
  endfunction

  function automatic logic [ADDR_W-1:0] payload_of(input logic [ADDR_W-1:0] base,
                                                    input logic [IDX_W-1:0]  idx);
    return base + ((ADDR_W'(idx) + ADDR_W'(1)) << GRAN_SHIFT);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/ffha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/ffha_ctrl.sv
// Request sequencer: first-fit walk, append, free and merge over the header RAM.
// Depends on ffha_pkg; drives one ffha_ram port pair.
`default_nettype none
module ffha_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ffha_pkg::cfg_t                 cfg,
  input  wire logic                           start,
  input  wire logic                           in_func,
  input  wire logic [ffha_pkg::REQ_W-1:0]     in_request_bytes,
  input  wire logic [ffha_pkg::ADDR_W-1:0]    in_block_address,
  input  wire logic                           in_address_valid,
  output logic                                busy,
  output ffha_pkg::res_t                      res,
  output logic                                ram_we,
  output logic      [ffha_pkg::IDX_W-1:0]     ram_waddr,
  output logic      [ffha_pkg::HDR_W-1:0]     ram_wdata,
  output logic      [ffha_pkg::IDX_W-1:0]     ram_raddr,
  input  wire logic [ffha_pkg::HDR_W-1:0]     ram_rdata
);
  import ffha_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_AREQ  = 3'd1;
  localparam logic [2:0] S_AEV   = 3'd2;
  localparam logic [2:0] S_FREQ0 = 3'd3;
  localparam logic [2:0] S_FEV0  = 3'd4;
  localparam logic [2:0] S_FREQ  = 3'd5;
  localparam logic [2:0] S_FEV   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [GRAN_W-1:0] top_r, top_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WALK_W-1:0] cur_r, cur_nxt;
  logic [GRAN_W-1:0] total_r, total_nxt;
  res_t              res_r, res_nxt;

  hdr_t               rd;
  logic [GRAN_W-1:0]  rd_size;
  logic [NEED_W-1:0]  in_need;
  logic [REQ_W:0]     bytes_up;
  logic [ADDR_W-1:0]  off;
  logic [OFF_W-1:0]   fidx;
  logic               free_ok;
  logic [LIMIT_W-1:0] lim;
  logic [SUM_W-1:0]   app_end;
  logic [SUM_W-1:0]   merged;
  hdr_t               wr;

  assign rd      = hdr_t'(ram_rdata);
  assign rd_size = size_clamp(rd.size);

  assign bytes_up = {1'b0, in_request_bytes} + (REQ_W+1)'(GRANULE_BYTES - 1);
  assign in_need  = bytes_up[REQ_W:GRAN_SHIFT];

  assign off     = in_block_address - cfg.heap_base;
  assign fidx    = off[ADDR_W-1:GRAN_SHIFT] - OFF_W'(1);
  assign free_ok = (off[GRAN_SHIFT-1:0] == '0) && (off[ADDR_W-1:GRAN_SHIFT] != '0)
                   && (fidx < OFF_W'(top_r));

  assign lim     = (cfg.heap_limit < LIMIT_W'(HEAP_GRANULES)) ?
                   cfg.heap_limit : LIMIT_W'(HEAP_GRANULES);
  assign app_end = SUM_W'(top_r) + SUM_W'(need_r) + SUM_W'(1);
  assign merged  = SUM_W'(total_r) + SUM_W'(rd_size) + SUM_W'(1);

  assign ram_wdata = wr;

  // Writes only occur on the last cycle of a request; the next request's first
  // read comes only after the sequencer has returned to idle, so no read can meet a pending write.
  always_comb begin
    state_nxt = state_r;
    top_nxt   = top_r;
    need_nxt  = need_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    total_nxt = total_r;
    res_nxt   = '{valid: 1'b0, status: ST_DONE, addr: '0};
    ram_we    = 1'b0;
    ram_waddr = cur_r[IDX_W-1:0];
    ram_raddr = cur_r[IDX_W-1:0];
    wr        = '{used: 1'b1, size: rd.size};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_func == FUNC_ALLOC) begin
            need_nxt = in_need;
            cur_nxt  = '0;
            if (in_need == '0) begin
              res_nxt.valid  = 1'b1;
              res_nxt.status = ST_ZERO;
            end else begin
              state_nxt = S_AREQ;
            end
          end else begin
            idx_nxt = fidx[IDX_W-1:0];
            if (in_address_valid && free_ok) begin
              state_nxt = S_FREQ0;
            end else begin
              res_nxt.valid = 1'b1;
            end
          end
        end
      end
      S_AREQ: begin
        if (cur_r < WALK_W'(top_r)) begin
          state_nxt = S_AEV;
        end else if (app_end <= SUM_W'(lim)) begin
          ram_we        = 1'b1;
          ram_waddr     = top_r[IDX_W-1:0];
          wr            = '{used: 1'b1, size: need_r[GRAN_W-1:0]};
          top_nxt       = GRAN_W'(app_end);
          res_nxt.valid = 1'b1;
          res_nxt.addr  = payload_of(cfg.heap_base, top_r[IDX_W-1:0]);
          state_nxt     = S_IDLE;
        end else begin
          res_nxt.valid  = 1'b1;
          res_nxt.status = ST_OOM;
          state_nxt      = S_IDLE;
        end
      end
      S_AEV: begin
        if (!rd.used && (SUM_W'(rd_size) >= SUM_W'(need_r))) begin
          ram_we        = 1'b1;
          wr            = '{used: 1'b1, size: rd.size};
          res_nxt.valid = 1'b1;
          res_nxt.addr  = payload_of(cfg.heap_base, cur_r[IDX_W-1:0]);
          state_nxt     = S_IDLE;
        end else begin
          cur_nxt   = cur_r + WALK_W'(rd_size) + WALK_W'(1);
          state_nxt = S_AREQ;
        end
      end
      S_FREQ0: begin
        ram_raddr = idx_r;
        state_nxt = S_FEV0;
      end
      S_FEV0: begin
        total_nxt = rd_size;
        cur_nxt   = WALK_W'(idx_r) + WALK_W'(rd_size) + WALK_W'(1);
        state_nxt = S_FREQ;
      end
      S_FREQ: begin
        ram_waddr = idx_r;
        wr        = '{used: 1'b0, size: total_r};
        if (cur_r < WALK_W'(top_r)) begin
          state_nxt = S_FEV;
        end else begin
          ram_we        = 1'b1;
          res_nxt.valid = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FEV: begin
        ram_waddr = idx_r;
        wr        = '{used: 1'b0, size: total_r};
        if (!rd.used) begin
          total_nxt = (merged > SUM_W'(HEAP_GRANULES)) ? GRAN_W'(HEAP_GRANULES)
                                                       : GRAN_W'(merged);
          cur_nxt   = cur_r + WALK_W'(rd_size) + WALK_W'(1);
          state_nxt = S_FREQ;
        end else begin
          ram_we        = 1'b1;
          res_nxt.valid = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      top_r   <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r  <= need_nxt;
    idx_r   <= idx_nxt;
    cur_r   <= cur_nxt;
    total_r <= total_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign res  = res_r;

endmodule
`default_nettype wire

>>> rtl/core/first_fit_heap_allocator.sv
// First-fit heap allocator top level: configuration registers, header RAM, sequencer.
// Depends on ffha_pkg, ffha_ram and ffha_ctrl.
//
// A request is taken when start is high and busy is low; its result appears on
// out_status/out_payload_address for one cycle with out_valid, and must be taken
// then. Zero-size allocates and null or bad frees answer the cycle after the
// request. An allocate walks the headers first fit, reading each header from the
// RAM in one state and evaluating it in the next; it answers from the evaluate
// state when it takes an existing free block, or from the read state past the
// last header with an append or an out-of-memory answer. A free reads the freed
// header, then reads and merges the following free headers in the same way, and
// answers when the walk stops at a block in use or at the heap top. The next
// request may be issued in the cycle the result is shown.
`default_nettype none
module first_fit_heap_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_func,
  input  wire logic [ffha_pkg::REQ_W-1:0]      in_request_bytes,
  input  wire logic [ffha_pkg::ADDR_W-1:0]     in_block_address,
  input  wire logic                            in_address_valid,
  output logic                                 out_valid,
  output logic      [1:0]                      out_status,
  output logic      [ffha_pkg::ADDR_W-1:0]     out_payload_address,
  input  wire logic                            cfg_we,
  input  wire logic [ffha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ffha_pkg::ADDR_W-1:0]     cfg_wdata
);
  import ffha_pkg::*;

  cfg_t             cfg_r;
  res_t             res;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [HDR_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [HDR_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heap_base  <= '0;
      cfg_r.heap_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAP_BASE:  cfg_r.heap_base  <= cfg_wdata;
        CFG_HEAP_LIMIT: cfg_r.heap_limit <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  ffha_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .start            (start),
    .in_func          (in_func),
    .in_request_bytes (in_request_bytes),
    .in_block_address (in_block_address),
    .in_address_valid (in_address_valid),
    .busy             (busy),
    .res              (res),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  ffha_ram #(
    .WIDTH (HDR_W),
    .DEPTH (HEAP_GRANULES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid           = res.valid;
  assign out_status          = res.status;
  assign out_payload_address = res.addr;

`ifndef NO_ASSERTIONS
  a_zero_req: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_ALLOC) && (in_request_bytes == '0))
    |=> (out_valid && (out_status == ST_ZERO)))
    else $error("zero-size request not answered next cycle");

  a_null_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_DONE)) |-> (out_payload_address == '0))
    else $error("null result carries an address");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while sequencer busy");

  a_no_pending_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> !busy)
    else $error("header write not on the last cycle of a request");
`endif

endmodule
`default_nettype wire

>>> bench/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_heap_allocator: allocate and free requests
// are checked against a heap model held in the bench. Depends on ffha_pkg and the RTL.
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int     CLK_PERIOD   = 12;
  localparam int     RESET_CYCLES = 10;
  localparam int     RANDOM_ITEMS = 1900;
  localparam int     PHASES       = 6;
  localparam int     DRAIN_CYCLES = 40;
  localparam longint CYCLE_LIMIT  = 40_000_000;

  typedef struct {
    logic              func;
    logic [REQ_W-1:0]  nbytes;
    logic [ADDR_W-1:0] addr;
    logic              aval;
  } heap_req_t;

  typedef struct {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
  } heap_ans_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_func = FUNC_ALLOC;
  logic [REQ_W-1:0]     in_request_bytes = '0;
  logic [ADDR_W-1:0]    in_block_address = '0;
  logic                 in_address_valid = 1'b0;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [ADDR_W-1:0]    out_payload_address;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_HEAP_BASE;
  logic [ADDR_W-1:0]    cfg_wdata = '0;

  heap_req_t         request_q[$];
  heap_ans_t         answer_q[$];
  int unsigned       hdr_size[HEAP_GRANULES];
  bit                hdr_used[HEAP_GRANULES];
  int unsigned       appended_q[$];
  int unsigned       heap_top_g = 0;
  logic [ADDR_W-1:0] base_r = '0;
  int unsigned       limit_r = HEAP_GRANULES;
  bit                taken = 1'b0;
  bit                gaps_on = 1'b1;
  int                gap_left = 0;
  int                err_cnt = 0;
  longint            cycles = 0;

  first_fit_heap_allocator uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_request_bytes    (in_request_bytes),
    .in_block_address    (in_block_address),
    .in_address_valid    (in_address_valid),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_payload_address (out_payload_address),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int unsigned clamp_size(input int unsigned s);
    return (s > HEAP_GRANULES) ? HEAP_GRANULES : s;
  endfunction

  function automatic logic [ADDR_W-1:0] block_addr(input int unsigned idx);
    return base_r + ADDR_W'(GRANULE_BYTES * (idx + 1));
  endfunction

  task automatic predict_answer(input heap_req_t r);
    int unsigned       need, idx, s, lim, total, nxt;
    logic [ADDR_W-1:0] off;
    bit                hit;
    heap_ans_t         a;
    a.status = ST_DONE;
    a.addr   = '0;
    if (r.func == FUNC_ALLOC) begin
      need = (32'(r.nbytes) + GRANULE_BYTES - 1) / GRANULE_BYTES;
      if (need == 0) begin
        a.status = ST_ZERO;
      end else begin
        idx = 0;
        hit = 1'b0;
        while (idx < heap_top_g && !hit) begin
          s = clamp_size(hdr_size[idx]);
          if (!hdr_used[idx] && s >= need) hit = 1'b1;
          else idx += s + 1;
        end
        if (hit) begin
          hdr_used[idx] = 1'b1;
          a.addr = block_addr(idx);
        end else begin
          lim = (limit_r < HEAP_GRANULES) ? limit_r : HEAP_GRANULES;
          if (heap_top_g + 1 + need <= lim) begin
            idx = heap_top_g;
            hdr_size[idx] = need;
            hdr_used[idx] = 1'b1;
            appended_q.push_back(idx);
            heap_top_g = idx + 1 + need;
            a.addr = block_addr(idx);
          end else begin
            a.status = ST_OOM;
          end
        end
      end
    end else if (r.aval) begin
      off = r.addr - base_r;
      if (off[GRAN_SHIFT-1:0] == '0 && off >= ADDR_W'(GRANULE_BYTES)) begin
        idx = off / GRANULE_BYTES - 1;
        if (idx < heap_top_g) begin
          hdr_used[idx] = 1'b0;
          total = clamp_size(hdr_size[idx]);
          nxt = idx + total + 1;
          // absorb following free blocks, headers included
          while (nxt < heap_top_g && !hdr_used[nxt]) begin
            s = clamp_size(hdr_size[nxt]);
            total += s + 1;
            if (total > HEAP_GRANULES) total = HEAP_GRANULES;
            nxt += s + 1;
          end
          hdr_size[idx] = total;
        end
      end
    end
    answer_q.push_back(a);
  endtask

  // frees only ever name headers that have been written: heap_top and the
  // set of appended headers never shrink, so this holds however far ahead we run
  function automatic heap_req_t random_request();
    heap_req_t   r;
    int unsigned idx, roll;
    int unsigned live_q[$];
    int unsigned chain_q[$];
    r.func   = ($urandom_range(0, 99) < 55) ? FUNC_ALLOC : FUNC_FREE;
    r.nbytes = $urandom;
    r.addr   = $urandom;
    r.aval   = $urandom_range(0, 1);
    if (r.func == FUNC_ALLOC) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) r.nbytes = '0;
      else if (roll < 8) r.nbytes = $urandom;
      else if (roll < 20) r.nbytes = $urandom_range(1, 64);
      else r.nbytes = $urandom_range(65, 1024);
    end else begin
      idx = 0;
      while (idx < heap_top_g) begin
        chain_q.push_back(idx);
        if (hdr_used[idx]) live_q.push_back(idx);
        idx += clamp_size(hdr_size[idx]) + 1;
      end
      r.aval = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 70 && live_q.size() > 0)
        r.addr = block_addr(live_q[$urandom_range(0, live_q.size() - 1)]);
      else if (roll < 80 && chain_q.size() > 0)
        r.addr = block_addr(chain_q[$urandom_range(0, chain_q.size() - 1)]);
      else if (roll < 85 && appended_q.size() > 0)
        r.addr = block_addr(appended_q[$urandom_range(0, appended_q.size() - 1)]);
      else if (roll < 90)
        r.aval = 1'b0;
      else if (roll < 94)
        r.addr = base_r + ADDR_W'($urandom_range(0, 8191) * 8 + $urandom_range(1, 7));
      else if (roll < 97)
        r.addr = base_r - ADDR_W'($urandom_range(0, 8));
      else
        r.addr = base_r + ADDR_W'((HEAP_GRANULES + 1 + $urandom_range(0, 1 << 20)) * 8);
    end
    return r;
  endfunction

  task automatic feed(input heap_req_t r);
    while (request_q.size() >= 3) @(posedge clk);
    request_q.push_back(r);
  endtask

  task automatic feed_req(input logic f, input logic [REQ_W-1:0] nb,
                          input logic [ADDR_W-1:0] ad, input logic av);
    heap_req_t r;
    r = '{f, nb, ad, av};
    feed(r);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || start || answer_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_HEAP_BASE) base_r = value;
    else limit_r = value[LIMIT_W-1:0];
  endtask

  // driver
  always @(negedge clk) begin
    heap_req_t nxt_req;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_q.size() > 0) begin
        nxt_req = request_q.pop_front();
        start            <= 1'b1;
        in_func          <= nxt_req.func;
        in_request_bytes <= nxt_req.nbytes;
        in_block_address <= nxt_req.addr;
        in_address_valid <= nxt_req.aval;
        if (gaps_on && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 9);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    heap_req_t seen;
    heap_ans_t want;
    taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      seen = '{in_func, in_request_bytes, in_block_address, in_address_valid};
      predict_answer(seen);
    end
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        err_cnt++;
        $error("answer with no request outstanding: status %0d address %h",
               out_status, out_payload_address);
      end else begin
        want = answer_q.pop_front();
        if (out_status !== want.status) begin
          err_cnt++;
          $error("out_status: expected %0d, actual %0d", want.status, out_status);
        end
        if (out_payload_address !== want.addr) begin
          err_cnt++;
          $error("out_payload_address: expected %h, actual %h", want.addr, out_payload_address);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_first_fit_heap_allocator: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed, from reset: base 0, limit 4096
    feed_req(FUNC_ALLOC, 16'd0,      32'h0,        1'b0);
    feed_req(FUNC_ALLOC, 16'd1,      32'hFFFFFFFF, 1'b1);
    feed_req(FUNC_ALLOC, 16'd8,      32'h0,        1'b0);
    feed_req(FUNC_ALLOC, 16'd9,      32'h0,        1'b1);
    feed_req(FUNC_ALLOC, 16'hFFFF,   32'h0,        1'b0);
    feed_req(FUNC_ALLOC, 16'h8000,   32'h0,        1'b0);
    feed_req(FUNC_FREE,  16'hFFFF,   32'd8,        1'b0);
    feed_req(FUNC_FREE,  16'd0,      32'd12,       1'b1);
    feed_req(FUNC_FREE,  16'd0,      32'd0,        1'b1);
    feed_req(FUNC_FREE,  16'd0,      32'd40000,    1'b1);
    feed_req(FUNC_FREE,  16'd0,      32'd24,       1'b1);
    feed_req(FUNC_FREE,  16'd0,      32'd8,        1'b1);
    feed_req(FUNC_FREE,  16'd0,      32'd8,        1'b1);
    feed_req(FUNC_ALLOC, 16'd24,     32'h0,        1'b0);
    feed_req(FUNC_FREE,  16'd0,      32'd24,       1'b1);
    feed_req(FUNC_ALLOC, 16'd8,      32'h0,        1'b0);
    feed_req(FUNC_FREE,  16'd0,      32'd40,       1'b1);
    feed_req(FUNC_ALLOC, 16'd16,     32'h0,        1'b0);
    feed_req(FUNC_FREE,  16'h0000,   32'hFFFFFFFF, 1'b1);
    feed_req(FUNC_ALLOC, 16'h7FF8,   32'h0,        1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(CFG_HEAP_BASE, 32'h0);
          write_reg(CFG_HEAP_LIMIT, $urandom & ~32'h1FFF);
        end
        1: begin
          write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF8);
          write_reg(CFG_HEAP_LIMIT, ($urandom & ~32'h1FFF) | 32'd1);
        end
        2: begin
          write_reg(CFG_HEAP_LIMIT, 32'd600);
          write_reg(CFG_HEAP_BASE, $urandom & ~32'h7);
        end
        3: begin
          write_reg(CFG_HEAP_BASE, $urandom);
          write_reg(CFG_HEAP_LIMIT, $urandom | 32'h1FFF);
        end
        4: begin
          write_reg(CFG_HEAP_BASE, $urandom & ~32'h7);
          write_reg(CFG_HEAP_LIMIT, ($urandom & ~32'h1FFF) | 32'd4096);
        end
        default: begin
          write_reg(CFG_HEAP_BASE, 32'h0);
          write_reg(CFG_HEAP_LIMIT, $urandom_range(1, 8191));
        end
      endcase
      gaps_on = (ph != PHASES - 1);
      repeat (RANDOM_ITEMS / PHASES) feed(random_request());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_first_fit_heap_allocator: done, clean");
    end else begin
      $display("tb_first_fit_heap_allocator: done, errors");
    end
    $finish;
  end

endmodule
